FILE: rtl/wsse_pkg.sv
`timescale 1ns / 1ps

package wsse_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_OSIZE,
        PH_DSIZE,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE     = 2'd0,
        KIND_BAD_HEADER = 2'd1,
        KIND_NO_DATA    = 2'd2,
        KIND_ZERO_FRAME = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } result_t;

    localparam logic [5:0]  HDR_LAST     = 6'd35;
    localparam logic [5:0]  HDR_TAG_END  = 6'd16;
    localparam logic [5:0]  HDR_GAP_LO   = 6'd4;
    localparam logic [5:0]  HDR_GAP_HI   = 6'd8;
    localparam logic [5:0]  HDR_CH_LO    = 6'd22;
    localparam logic [5:0]  HDR_CH_HI    = 6'd23;
    localparam logic [5:0]  HDR_BITS_LO  = 6'd34;
    localparam logic [5:0]  HDR_BITS_HI  = 6'd35;
    localparam logic [31:0] DATA_TAG_LE  = 32'h6174_6164;
    localparam logic [2:0]  FIELD_BYTES  = 3'd4;
    localparam logic [15:0] BITS_8       = 16'd8;
    localparam logic [15:0] MONO         = 16'd1;
    localparam logic [7:0]  U8_OFFSET    = 8'h80;

    // expected header tag byte, gap bytes at 4..7 are never compared
    function automatic logic [7:0] tag_byte(input logic [3:0] off);
        logic [7:0] b;
        case (off)
            4'd0:    b = 8'h52;
            4'd1:    b = 8'h49;
            4'd2:    b = 8'h46;
            4'd3:    b = 8'h46;
            4'd8:    b = 8'h57;
            4'd9:    b = 8'h41;
            4'd10:   b = 8'h56;
            4'd11:   b = 8'h45;
            4'd12:   b = 8'h66;
            4'd13:   b = 8'h6d;
            4'd14:   b = 8'h74;
            4'd15:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/wav_stream_sample_extractor_top.sv
`timescale 1ns / 1ps

// wav byte stream to stereo q1.15 samples
// s_ channel: one file byte per beat in s_tdata, s_tlast on the final byte of
// a file. the byte after a tlast beat starts a new file
// m_ channel: one result per beat. m_tuser carries the kind (sample, bad header
// tags, missing data chunk, zero frame size), m_tdata the left and right
// samples, m_tlast the final frame of the data chunk. error results carry zero
// samples and are sent once, after which the rest of the file is dropped
// throughput: one byte per cycle while s_tready is high, set by the single
// register stage that holds the parser state; the frame size product is kept
// in its own register
// a two-entry output buffer lets a byte be taken while a result waits;
// s_tready is low for every cycle in which the second entry holds a result
// reset clears the parser to the start of a file and empties the output buffer
module wav_stream_sample_extractor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import wsse_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  hdr_off_reg, hdr_off_next;
    logic        tag_failed_reg, tag_failed_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  field_idx_reg, field_idx_next;
    logic [31:0] remain_reg, remain_next;
    logic [28:0] frame_off_reg, frame_off_next;
    logic [31:0] capture_reg, capture_next;
    logic [28:0] fsize_reg;

    logic        in_accept;
    logic        res_valid;
    result_t     res;

    result_t     main_reg, skid_reg;
    logic        main_valid_reg, skid_valid_reg;
    logic        pop;

    assign s_tready  = ~skid_valid_reg;
    assign in_accept = s_tvalid & s_tready;

    always_comb begin
        logic [31:0] word_new;
        logic [2:0]  idx_inc;
        logic [31:0] rem_dec;
        logic [28:0] off_inc;
        logic [31:0] cap_new;
        logic [15:0] l_val, r_val;

        phase_next      = phase_reg;
        hdr_off_next    = hdr_off_reg;
        tag_failed_next = tag_failed_reg;
        chan_next       = chan_reg;
        bits_next       = bits_reg;
        word_next       = word_reg;
        field_idx_next  = field_idx_reg;
        remain_next     = remain_reg;
        frame_off_next  = frame_off_reg;
        capture_next    = capture_reg;
        res_valid       = 1'b0;
        res             = '{kind: KIND_SAMPLE, left: 16'h0, right: 16'h0, last: 1'b0};

        word_new = {s_tdata, word_reg[31:8]};
        idx_inc  = field_idx_reg + 3'd1;
        rem_dec  = remain_reg - 32'd1;
        off_inc  = frame_off_reg + 29'd1;
        cap_new  = capture_reg;
        l_val    = 16'h0;
        r_val    = 16'h0;

        if (in_accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_off_reg < HDR_TAG_END &&
                        (hdr_off_reg < HDR_GAP_LO || hdr_off_reg >= HDR_GAP_HI) &&
                        s_tdata != tag_byte(hdr_off_reg[3:0]))
                        tag_failed_next = 1'b1;
                    if (hdr_off_reg == HDR_CH_LO)   chan_next = {8'h00, s_tdata};
                    if (hdr_off_reg == HDR_CH_HI)   chan_next = {s_tdata, chan_reg[7:0]};
                    if (hdr_off_reg == HDR_BITS_LO) bits_next = {8'h00, s_tdata};
                    if (hdr_off_reg == HDR_BITS_HI) bits_next = {s_tdata, bits_reg[7:0]};
                    if (hdr_off_reg >= HDR_LAST) begin
                        if (tag_failed_reg) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_BAD_HEADER;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next     = PH_ID;
                            field_idx_next = 3'd0;
                        end
                    end else begin
                        hdr_off_next = hdr_off_reg + 6'd1;
                    end
                end
                PH_ID, PH_OSIZE, PH_DSIZE: begin
                    word_next      = word_new;
                    field_idx_next = idx_inc;
                    if (idx_inc >= FIELD_BYTES) begin
                        field_idx_next = 3'd0;
                        if (phase_reg == PH_ID) begin
                            phase_next = (word_new == DATA_TAG_LE) ? PH_DSIZE : PH_OSIZE;
                        end else if (phase_reg == PH_OSIZE) begin
                            remain_next = word_new;
                            phase_next  = (word_new != 32'd0) ? PH_SKIP : PH_ID;
                        end else if (fsize_reg == 29'd0) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_ZERO_FRAME;
                            phase_next = PH_DONE;
                        end else begin
                            remain_next    = word_new;
                            frame_off_next = 29'd0;
                            capture_next   = 32'd0;
                            phase_next     = (word_new < {3'b000, fsize_reg}) ? PH_DONE
                                                                              : PH_DATA;
                        end
                    end
                end
                PH_SKIP: begin
                    remain_next = rem_dec;
                    if (rem_dec == 32'd0) phase_next = PH_ID;
                end
                PH_DATA: begin
                    // only the first four bytes of a frame are kept
                    if (frame_off_reg < 29'd4) begin
                        case (frame_off_reg[1:0])
                            2'd0:    cap_new = capture_reg | {24'h0, s_tdata};
                            2'd1:    cap_new = capture_reg | {16'h0, s_tdata, 8'h0};
                            2'd2:    cap_new = capture_reg | {8'h0, s_tdata, 16'h0};
                            default: cap_new = capture_reg | {s_tdata, 24'h0};
                        endcase
                    end
                    remain_next = rem_dec;
                    if (off_inc == fsize_reg) begin
                        if (bits_reg == BITS_8) begin
                            l_val = {cap_new[7:0] ^ U8_OFFSET, 8'h00};
                            r_val = {cap_new[15:8] ^ U8_OFFSET, 8'h00};
                        end else begin
                            l_val = cap_new[15:0];
                            r_val = cap_new[31:16];
                        end
                        if (chan_reg == MONO) r_val = l_val;
                        res_valid      = 1'b1;
                        res.kind       = KIND_SAMPLE;
                        res.left       = l_val;
                        res.right      = r_val;
                        res.last       = (rem_dec < {3'b000, fsize_reg}) || s_tlast;
                        frame_off_next = 29'd0;
                        capture_next   = 32'd0;
                    end else begin
                        frame_off_next = off_inc;
                        capture_next   = cap_new;
                    end
                    if (rem_dec < {3'b000, fsize_reg}) phase_next = PH_DONE;
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            if (s_tlast) begin
                if (!res_valid) begin
                    if (phase_next == PH_HEADER) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_BAD_HEADER;
                    end else if (phase_next == PH_ID || phase_next == PH_OSIZE ||
                                 phase_next == PH_DSIZE || phase_next == PH_SKIP) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_NO_DATA;
                    end
                end
                // next beat starts a new file
                phase_next      = PH_HEADER;
                hdr_off_next    = 6'd0;
                tag_failed_next = 1'b0;
                chan_next       = 16'd0;
                bits_next       = 16'd0;
                word_next       = 32'd0;
                field_idx_next  = 3'd0;
                remain_next     = 32'd0;
                frame_off_next  = 29'd0;
                capture_next    = 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_off_reg    <= 6'd0;
            tag_failed_reg <= 1'b0;
            chan_reg       <= 16'd0;
            bits_reg       <= 16'd0;
            word_reg       <= 32'd0;
            field_idx_reg  <= 3'd0;
            remain_reg     <= 32'd0;
            frame_off_reg  <= 29'd0;
            capture_reg    <= 32'd0;
        end else begin
            phase_reg      <= phase_next;
            hdr_off_reg    <= hdr_off_next;
            tag_failed_reg <= tag_failed_next;
            chan_reg       <= chan_next;
            bits_reg       <= bits_next;
            word_reg       <= word_next;
            field_idx_reg  <= field_idx_next;
            remain_reg     <= remain_next;
            frame_off_reg  <= frame_off_next;
            capture_reg    <= capture_next;
        end
    end

    // format fields are stable long before the data size arrives
    always_ff @(posedge aclk) begin
        fsize_reg <= bits_reg[15:3] * chan_reg;
    end

    assign pop = main_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= res;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {main_reg.right, main_reg.left};
    assign m_tuser  = main_reg.kind;
    assign m_tlast  = main_reg.last;

endmodule
